>>> design/crc_gc_pkg.sv
// Package for the CRC generate and check core.
// Holds the result type, register indexes and fixed constants.
// No dependencies.
package crc_gc_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int PB_W      = 4;
    localparam int CNT_W     = 4;

    localparam logic [CNT_W-1:0] CNT_SAT = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR  = 2'd2;

    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    typedef struct packed {
        logic              end_of_run;
        logic              check_pass;
        logic              is_crc;
        logic [BYTE_W-1:0] out_byte;
    } res_t;

endpackage

>>> design/crc_gc_skid.sv
// Output register with a skid entry for the CRC core result stream.
// Depends on crc_gc_pkg for the result type.
// Its ready output is registered, which separates upstream from m_tready.
module crc_gc_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  crc_gc_pkg::res_t  in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output crc_gc_pkg::res_t  out_res
);
    import crc_gc_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_res_reg <= skid_res_reg;
            end else if (in_valid) begin
                out_res_reg <= in_res;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_res_reg <= in_res;
        end
    end

endmodule

>>> design/crc_gc_core.sv
// Configuration registers, input register, remainder update and CRC flush sequencer.
// Depends on crc_gc_pkg; results go to the output skid stage.
module crc_gc_core #(
    parameter int MAX_POLY_BYTES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [crc_gc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crc_gc_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [crc_gc_pkg::BYTE_W-1:0]       in_data,
    input  logic                                in_last,
    output logic                                res_valid,
    input  logic                                res_ready,
    output crc_gc_pkg::res_t                    res
);
    import crc_gc_pkg::*;

    localparam int RW = BYTE_W * MAX_POLY_BYTES;
    localparam int LW = $clog2(MAX_POLY_BYTES + 1);
    localparam int KW = (MAX_POLY_BYTES > 1) ? $clog2(MAX_POLY_BYTES) : 1;

    typedef enum logic [1:0] {ST_RUN, ST_CALC, ST_EMIT} state_t;

    function automatic logic [RW-1:0] step8(input logic [RW-1:0] acc_in,
                                            input logic [BYTE_W-1:0] d,
                                            input logic [RW-1:0] top,
                                            input logic [RW-1:0] g);
        logic [RW-1:0] acc;
        acc = acc_in;
        for (int j = BYTE_W - 1; j >= 0; j--) begin
            acc = {acc[RW-2:0], d[j]};
            if ((acc & top) != '0) begin
                acc = acc ^ g;
            end
        end
        return acc;
    endfunction

    logic              mode_reg;
    logic [PB_W-1:0]   pb_reg;
    logic [RW-1:0]     gen_reg;
    logic [LW-1:0]     len_reg;
    logic [RW-1:0]     top_reg;
    logic [RW-1:0]     low_reg;
    logic [RW-1:0]     g_reg;
    logic [LW-1:0]     len_next;
    logic [RW-1:0]     top_next;
    logic [RW-1:0]     low_next;
    logic [RW-1:0]     g_next;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     rem_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [RW-1:0]     crc_reg;
    logic [RW-1:0]     crc_next;
    logic [KW-1:0]     k_reg;
    logic [KW-1:0]     k_next;

    logic              proceed;
    logic [RW-1:0]     acc_c;
    logic [CNT_W-1:0]  count_inc;
    logic [KW-1:0]     k_last;
    logic [KW-1:0]     emit_idx;
    logic [RW-1:0]     emit_shift;
    logic              pass_c;

    always_comb begin
        if (pb_reg == '0) begin
            len_next = LW'(1);
        end else if (int'(pb_reg) > MAX_POLY_BYTES) begin
            len_next = LW'(MAX_POLY_BYTES);
        end else begin
            len_next = LW'(pb_reg);
        end
        top_next = RW'(1) << (BYTE_W * int'(len_next) - 1);
        low_next = top_next - RW'(1);
        g_next   = (gen_reg & (top_next | low_next)) | top_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_GENERATE;
            pb_reg   <= PB_W'(2);
            gen_reg  <= RW'(42089);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:       mode_reg <= cfg_wr_data[0];
                REG_POLY_BYTES: pb_reg   <= cfg_wr_data[PB_W-1:0];
                REG_GENERATOR:  gen_reg  <= cfg_wr_data[RW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        top_reg <= top_next;
        low_reg <= low_next;
        g_reg   <= g_next;
    end

    assign proceed   = (state_reg == ST_RUN) && in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || proceed;
    assign acc_c     = step8(rem_reg & low_reg, in_data_reg, top_reg, g_reg);
    assign count_inc = (count_reg == CNT_SAT) ? CNT_SAT : count_reg + CNT_W'(1);
    assign pass_c    = (acc_c == '0) && (count_inc >= CNT_W'(len_reg) + CNT_W'(1));
    assign k_last    = KW'(len_reg - LW'(1));
    assign emit_idx  = k_last - k_reg;
    assign emit_shift = crc_reg >> {emit_idx, 3'b000};

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        k_next     = k_reg;
        res_valid  = 1'b0;
        res        = '{end_of_run: 1'b0, check_pass: 1'b0, is_crc: 1'b0, out_byte: ZERO_BYTE};
        unique case (state_reg)
            ST_RUN: begin
                if (mode_reg == MODE_GENERATE) begin
                    res_valid = in_valid_reg;
                    res = '{end_of_run: !in_last_reg, check_pass: 1'b0, is_crc: 1'b0,
                            out_byte: in_data_reg};
                end else begin
                    res_valid = in_valid_reg && in_last_reg;
                    res = '{end_of_run: 1'b1, check_pass: pass_c, is_crc: 1'b0,
                            out_byte: ZERO_BYTE};
                end
                if (proceed) begin
                    if (in_last_reg) begin
                        rem_next   = '0;
                        count_next = '0;
                        if (mode_reg == MODE_GENERATE) begin
                            crc_next   = acc_c;
                            k_next     = '0;
                            state_next = ST_CALC;
                        end
                    end else begin
                        rem_next   = acc_c;
                        count_next = count_inc;
                    end
                end
            end
            ST_CALC: begin
                crc_next = step8(crc_reg, ZERO_BYTE, top_reg, g_reg);
                if (k_reg == k_last) begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                res = '{end_of_run: (k_reg == k_last), check_pass: 1'b0, is_crc: 1'b1,
                        out_byte: emit_shift[BYTE_W-1:0]};
                if (res_ready) begin
                    if (k_reg == k_last) begin
                        k_next     = '0;
                        state_next = ST_RUN;
                    end else begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            rem_reg      <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (in_ready && in_valid) begin
            in_data_reg <= in_data;
            in_last_reg <= in_last;
        end
    end

endmodule

>>> design/crc_generate_and_check_core.sv
// Top level of the CRC generate and check core.
// Instantiates crc_gc_core and crc_gc_skid; depends on crc_gc_pkg.
//
//   Channel   Direction  Transfer content
//   s_        in         tdata[7:0] data_byte, tlast last_byte
//   m_        out        tdata[7:0] out_byte, tuser[0] is_crc, tuser[1] check_pass,
//                        tlast end_of_run
//   cfg_      in         write enable, register index, 64-bit write data
//
// A byte accepted into the input register is worked on from there, and its result, if any,
// is registered in the output stage; bytes stream at one per cycle while no flush runs and
// the output stage has room. A last byte in generate mode starts a flush: L steps of eight
// zero-bit reductions each, then the L CRC bytes are sent. Meanwhile at most one further
// byte is taken into the input register, where it waits. The output has a registered skid
// stage, so m_tready never reaches s_tready in the same cycle. Reset is synchronous.
module crc_generate_and_check_core #(
    parameter int MAX_POLY_BYTES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [crc_gc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crc_gc_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // out_byte
    output logic [1:0]                        m_tuser,   // is_crc, check_pass
    output logic                              m_tlast
);
    import crc_gc_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;
    res_t out_res;

    crc_gc_core #(
        .MAX_POLY_BYTES(MAX_POLY_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    crc_gc_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_res   (res),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = {out_res.check_pass, out_res.is_crc};
    assign m_tlast = out_res.end_of_run;

endmodule

>>> test/testbench.sv
// Self-checking testbench for crc_generate_and_check_core: directed and random byte streams
// in both modes, predicted by a bitwise CRC divider kept inside this file.
// Depends on crc_gc_pkg and the RTL of the core.
`timescale 1ns / 100ps

module testbench;
    import crc_gc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int MAX_LEN       = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 5_000_000;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = '0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [7:0]           m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    // Register mirror and divider state of the predictor.
    logic             cfg_mode = MODE_GENERATE;
    logic [PB_W-1:0]  cfg_len  = 4'd2;
    logic [63:0]      cfg_gen  = 64'd42089;
    logic [63:0]      pred_rem = '0;
    logic [CNT_W-1:0] pred_cnt = '0;

    res_t        expected_res_q[$];
    res_t        want_res;
    logic [7:0]  msg_buf[$];
    int unsigned err_count       = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned rx_hold_req     = 0;
    int unsigned rx_hold_ack     = 0;
    int unsigned rx_hold_left    = 0;

    crc_generate_and_check_core #(
        .MAX_POLY_BYTES(MAX_LEN)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_len();
        if (cfg_len == 0) return 1;
        if (cfg_len > MAX_LEN) return MAX_LEN;
        return cfg_len;
    endfunction

    function automatic logic [63:0] poly_top();
        return 64'd1 << (8 * eff_len() - 1);
    endfunction

    function automatic logic [63:0] poly_g();
        logic [63:0] top;
        top = poly_top();
        return (cfg_gen & (top | (top - 1))) | top;
    endfunction

    function automatic logic [63:0] fold_bit(logic [63:0] acc, logic b);
        acc = {acc[62:0], b};
        if ((acc & poly_top()) != 0) acc ^= poly_g();
        return acc;
    endfunction

    function automatic logic [63:0] fold_byte(logic [63:0] acc, logic [7:0] b);
        for (int j = 7; j >= 0; j--) acc = fold_bit(acc, b[j]);
        return acc;
    endfunction

    function automatic logic [63:0] crc_tail(logic [63:0] acc);
        for (int k = 0; k < 8 * eff_len(); k++) acc = fold_bit(acc, 1'b0);
        return acc;
    endfunction

    function automatic logic [63:0] crc_of_buf();
        logic [63:0] acc;
        acc = '0;
        foreach (msg_buf[i]) acc = fold_byte(acc, msg_buf[i]);
        return crc_tail(acc);
    endfunction

    // Works out the results that one accepted byte causes and advances the divider state.
    task automatic crc_predict_byte(input logic [7:0] b, input logic last);
        int unsigned len;
        logic [63:0] acc;
        logic [63:0] crc;
        res_t r;
        len = eff_len();
        acc = fold_byte(pred_rem & (poly_top() - 1), b);
        if (pred_cnt < CNT_SAT) pred_cnt = pred_cnt + 1'b1;
        if (cfg_mode == MODE_GENERATE) begin
            r.out_byte   = b;
            r.is_crc     = 1'b0;
            r.check_pass = 1'b0;
            r.end_of_run = !last;
            expected_res_q.push_back(r);
            if (last) begin
                crc = crc_tail(acc);
                for (int k = 0; k < len; k++) begin
                    r.out_byte   = 8'(crc >> (8 * (len - 1 - k)));
                    r.is_crc     = 1'b1;
                    r.check_pass = 1'b0;
                    r.end_of_run = (k == len - 1);
                    expected_res_q.push_back(r);
                end
            end
        end else if (last) begin
            r.out_byte   = ZERO_BYTE;
            r.is_crc     = 1'b0;
            r.check_pass = (acc == 0) && (pred_cnt >= len + 1);
            r.end_of_run = 1'b1;
            expected_res_q.push_back(r);
        end
        if (last) begin
            pred_rem = '0;
            pred_cnt = '0;
        end else begin
            pred_rem = acc;
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:       cfg_mode = data[0];
            REG_POLY_BYTES: cfg_len  = data[PB_W-1:0];
            REG_GENERATOR:  cfg_gen  = data;
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry random values.
    task automatic apply_config(input logic m, input logic [PB_W-1:0] pb, input logic [63:0] gen);
        logic [CFG_W-1:0] d;
        d = {$urandom, $urandom};
        d[0] = m;
        cfg_write(REG_MODE, d);
        d = {$urandom, $urandom};
        d[PB_W-1:0] = pb;
        cfg_write(REG_POLY_BYTES, d);
        cfg_write(REG_GENERATOR, gen);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        crc_predict_byte(b, last);
    endtask

    task automatic send_buf();
        foreach (msg_buf[i]) send_byte(msg_buf[i], i == msg_buf.size() - 1);
    endtask

    task automatic append_crc();
        logic [63:0] crc;
        int unsigned len;
        len = eff_len();
        crc = crc_of_buf();
        for (int k = 0; k < len; k++) msg_buf.push_back(8'(crc >> (8 * (len - 1 - k))));
    endtask

    task automatic send_message(input int unsigned n_data, input bit well_formed,
                                input bit corrupt);
        int unsigned pos;
        msg_buf.delete();
        repeat (n_data) msg_buf.push_back(8'($urandom_range(255)));
        if (well_formed) append_crc();
        if (msg_buf.size() == 0) msg_buf.push_back(8'($urandom_range(255)));
        if (corrupt) begin
            pos = $urandom_range(msg_buf.size() - 1);
            msg_buf[pos] = msg_buf[pos] ^ (8'd1 << $urandom_range(7));
        end
        send_buf();
    endtask

    task automatic wait_until_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_res_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack  = rx_hold_req;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_res_q.size() == 0) begin
                $display("%0t: unexpected transfer, tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want_res = expected_res_q.pop_front();
                if (m_tdata !== want_res.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want_res.out_byte, m_tdata);
                    err_count++;
                end
                if (m_tuser[0] !== want_res.is_crc) begin
                    $display("%0t: is_crc expected %b actual %b",
                             $time, want_res.is_crc, m_tuser[0]);
                    err_count++;
                end
                if (m_tuser[1] !== want_res.check_pass) begin
                    $display("%0t: check_pass expected %b actual %b",
                             $time, want_res.check_pass, m_tuser[1]);
                    err_count++;
                end
                if (m_tlast !== want_res.end_of_run) begin
                    $display("%0t: end_of_run expected %b actual %b",
                             $time, want_res.end_of_run, m_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic test_generate_defaults();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        msg_buf = '{8'h00, 8'hFF, 8'h80, 8'h01};
        send_buf();
        msg_buf = '{8'hA5};
        send_buf();
    endtask

    task automatic test_check_verdicts();
        wait_until_idle();
        apply_config(MODE_CHECK, 4'd2, 64'd42089);
        msg_buf = '{8'h12, 8'h34};
        append_crc();
        send_buf();
        msg_buf = '{8'h12, 8'h34};
        append_crc();
        msg_buf[3] = msg_buf[3] ^ 8'h01;
        send_buf();
        // A zero remainder alone is not enough when the message is too short.
        msg_buf = '{8'h00, 8'h00};
        send_buf();
        msg_buf = '{8'hFF};
        send_buf();
    endtask

    task automatic test_length_extremes();
        wait_until_idle();
        apply_config(MODE_GENERATE, 4'd0, '1);
        msg_buf = '{8'hC3, 8'h5A};
        send_buf();
        wait_until_idle();
        apply_config(MODE_GENERATE, 4'd15, {$urandom, $urandom});
        cfg_write(REG_SPARE, {$urandom, $urandom});
        msg_buf = '{8'hFF};
        send_buf();
    endtask

    task automatic test_mid_message_change();
        wait_until_idle();
        apply_config(MODE_GENERATE, 4'd8, {$urandom, $urandom});
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        wait_until_idle();
        cfg_write(REG_POLY_BYTES, 64'd1);
        cfg_write(REG_GENERATOR, {$urandom, $urandom});
        send_byte(8'hBE, 1'b1);
    endtask

    task automatic test_output_backpressure();
        wait_until_idle();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        apply_config(MODE_GENERATE, 4'd8, {$urandom, $urandom});
        rx_hold_req = rx_hold_req + 1;
        send_message(20, 0, 0);
        send_message(20, 0, 0);
    endtask

    task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                       input int unsigned n_bytes);
        int unsigned done;
        int unsigned n;
        logic m;
        logic [PB_W-1:0] pb;
        logic [63:0] gen;
        done = 0;
        while (done < n_bytes) begin
            wait_until_idle();
            sender_idle_pct = s_pct;
            recv_stall_pct  = r_pct;
            m = 1'($urandom_range(1));
            case ($urandom_range(5))
                0: pb = 4'd0;
                1: pb = 4'd1;
                2: pb = 4'd8;
                3: pb = PB_W'($urandom_range(15, 9));
                default: pb = PB_W'($urandom_range(8, 1));
            endcase
            case ($urandom_range(7))
                0: gen = '0;
                1: gen = '1;
                default: gen = {$urandom, $urandom};
            endcase
            apply_config(m, pb, gen);
            repeat (4) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(4, 0);
                if (m == MODE_CHECK && $urandom_range(9) < 7)
                    send_message(n, 1, $urandom_range(4) == 0);
                else
                    send_message(n, 0, 0);
                done += msg_buf.size();
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_generate_defaults();
        test_check_verdicts();
        test_length_extremes();
        test_mid_message_change();
        test_output_backpressure();
        test_random_traffic(0, 0, 85);
        test_random_traffic(88, 0, 85);
        test_random_traffic(0, 88, 85);
        test_random_traffic(31, 31, 85);
        wait_until_idle();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Test completed with failures");
        $finish;
    end

endmodule
